[sv/rse_pkg.sv]
package rse_pkg;

  // Command codes
  localparam logic [2:0] CMD_PUSH   = 3'd0;
  localparam logic [2:0] CMD_POP    = 3'd1;
  localparam logic [2:0] CMD_PEEK   = 3'd2;
  localparam logic [2:0] CMD_DUP    = 3'd3;
  localparam logic [2:0] CMD_ROT_UP = 3'd4;
  localparam logic [2:0] CMD_ROT_DN = 3'd5;
  localparam logic [2:0] CMD_PRINT  = 3'd6;

  // Status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_IGNORED = 2'd3;

  // Field widths and register reset
  localparam int unsigned CMD_W   = 3;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned COUNT_W = 5;
  localparam logic [COUNT_W-1:0] CAP_RESET = 5'd16;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RD_RSP,
    S_ROT_SAVE,
    S_ROT_MOVE,
    S_ROT_TAIL,
    S_PRINT
  } state_t;

endpackage

[sv/rse_ram.sv]
module rse_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int DW    = 8
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  // Write one entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Register the read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[sv/rotating_stack_engine.sv]
// Byte-wide LIFO stack with push, pop, peek, dup, up/down rotate and print. An item is taken
// when start is high while busy is low; cfg_we loads the capacity register (clamped to DEPTH)
// and must only be used while the block is idle. Results appear for exactly one cycle with
// out_valid high, and the final result of an item is on the ports in the first cycle that busy
// is low again; the receiver cannot stall them, so it must take every result as it comes. busy
// covers the execute state on push and on items that only report a status; pop, peek and dup
// add a read-response state; a rotate of n entries saves the wrapping entry, moves the other
// n-1 and writes it back; print streams one result per cycle top to bottom with out_last on
// the final one. Each step uses each port of the single-read, single-write stack memory at
// most once, so rotates and prints scale with the number of entries they touch.
module rotating_stack_engine
  import rse_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [CMD_W-1:0]   in_cmd,
  input  logic [BYTE_W-1:0]  in_push_value,
  input  logic [COUNT_W-1:0] in_rotate_count,
  input  logic               cfg_we,
  input  logic [COUNT_W-1:0] cfg_wdata,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic [BYTE_W-1:0]  out_value,
  output logic               out_value_valid,
  output logic               out_last
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW = $clog2(DEPTH + 1);
  localparam int CW = (FW > COUNT_W) ? FW : COUNT_W;

  state_t state_r, state_nxt;

  logic [CMD_W-1:0]   cmd_r, cmd_nxt;
  logic [BYTE_W-1:0]  pv_r, pv_nxt;
  logic [COUNT_W-1:0] rc_r, rc_nxt;
  logic [COUNT_W-1:0] cap_r, cap_nxt;
  logic [FW-1:0]      fill_r, fill_nxt;
  logic [FW-1:0]      cnt_r, cnt_nxt;
  logic [AW-1:0]      ptr_r, ptr_nxt;
  logic [AW-1:0]      wptr_r, wptr_nxt;
  logic [BYTE_W-1:0]  hold_r, hold_nxt;
  logic               dir_up_r, dir_up_nxt;

  logic               ov_r, ov_nxt;
  logic [1:0]         ost_r, ost_nxt;
  logic [BYTE_W-1:0]  oval_r, oval_nxt;
  logic               ovv_r, ovv_nxt;
  logic               olast_r, olast_nxt;

  logic               ram_wr_en, ram_rd_en;
  logic [AW-1:0]      ram_wr_addr, ram_rd_addr;
  logic [BYTE_W-1:0]  ram_wr_data, ram_rd_data;

  logic [CW-1:0]      cap_eff;
  logic               empty, full, rot_bad;
  logic [AW-1:0]      top_addr, base_addr;

  // Decode the stack condition
  assign cap_eff   = (CW'(cap_r) > CW'(DEPTH)) ? CW'(DEPTH) : CW'(cap_r);
  assign empty     = (fill_r == '0);
  assign full      = (CW'(fill_r) >= cap_eff);
  assign rot_bad   = (CW'(rc_r) < CW'(2)) || (CW'(rc_r) > CW'(fill_r));
  assign top_addr  = AW'(fill_r - FW'(1));
  assign base_addr = AW'(CW'(fill_r) - CW'(rc_r));

  rse_ram #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (BYTE_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        case (cmd_r) inside
          CMD_POP, CMD_PEEK: state_nxt = empty ? S_IDLE : S_RD_RSP;
          CMD_DUP:           state_nxt = (empty || full) ? S_IDLE : S_RD_RSP;
          CMD_ROT_UP, CMD_ROT_DN: state_nxt = rot_bad ? S_IDLE : S_ROT_SAVE;
          CMD_PRINT:         state_nxt = empty ? S_IDLE : S_PRINT;
          default:           state_nxt = S_IDLE;
        endcase
      end
      S_RD_RSP:   state_nxt = S_IDLE;
      S_ROT_SAVE: state_nxt = S_ROT_MOVE;
      S_ROT_MOVE: begin
        if (cnt_r == FW'(1)) begin
          state_nxt = S_ROT_TAIL;
        end
      end
      S_ROT_TAIL: state_nxt = S_IDLE;
      S_PRINT: begin
        if (cnt_r == FW'(1)) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath, memory access and results
  always_comb begin
    cmd_nxt     = cmd_r;
    pv_nxt      = pv_r;
    rc_nxt      = rc_r;
    cap_nxt     = cfg_we ? cfg_wdata : cap_r;
    fill_nxt    = fill_r;
    cnt_nxt     = cnt_r;
    ptr_nxt     = ptr_r;
    wptr_nxt    = wptr_r;
    hold_nxt    = hold_r;
    dir_up_nxt  = dir_up_r;
    ov_nxt      = 1'b0;
    ost_nxt     = ST_OK;
    oval_nxt    = '0;
    ovv_nxt     = 1'b0;
    olast_nxt   = 1'b0;
    ram_wr_en   = 1'b0;
    ram_wr_addr = '0;
    ram_wr_data = '0;
    ram_rd_en   = 1'b0;
    ram_rd_addr = '0;

    unique case (state_r)
      S_IDLE: begin
        // Latch the item
        if (start) begin
          cmd_nxt = in_cmd;
          pv_nxt  = in_push_value;
          rc_nxt  = in_rotate_count;
        end
      end
      S_EXEC: begin
        case (cmd_r) inside
          CMD_PUSH: begin
            ov_nxt    = 1'b1;
            olast_nxt = 1'b1;
            if (full) begin
              ost_nxt = ST_FULL;
            end else begin
              ram_wr_en   = 1'b1;
              ram_wr_addr = AW'(fill_r);
              ram_wr_data = pv_r;
              fill_nxt    = fill_r + FW'(1);
            end
          end
          CMD_POP, CMD_PEEK, CMD_DUP: begin
            if (empty) begin
              ov_nxt    = 1'b1;
              olast_nxt = 1'b1;
              ost_nxt   = ST_EMPTY;
            end else if (cmd_r == CMD_DUP && full) begin
              ov_nxt    = 1'b1;
              olast_nxt = 1'b1;
              ost_nxt   = ST_FULL;
            end else begin
              ram_rd_en   = 1'b1;
              ram_rd_addr = top_addr;
            end
          end
          CMD_ROT_UP, CMD_ROT_DN: begin
            if (rot_bad) begin
              ov_nxt    = 1'b1;
              olast_nxt = 1'b1;
              ost_nxt   = ST_IGNORED;
            end else begin
              // Read the entry that wraps around
              dir_up_nxt  = (cmd_r == CMD_ROT_UP);
              ram_rd_en   = 1'b1;
              ram_rd_addr = (cmd_r == CMD_ROT_UP) ? top_addr : base_addr;
              ptr_nxt     = (cmd_r == CMD_ROT_UP) ? top_addr - AW'(1)
                                                  : base_addr + AW'(1);
              wptr_nxt    = (cmd_r == CMD_ROT_UP) ? top_addr : base_addr;
              cnt_nxt     = FW'(rc_r - COUNT_W'(1));
            end
          end
          CMD_PRINT: begin
            if (empty) begin
              ov_nxt    = 1'b1;
              olast_nxt = 1'b1;
              ost_nxt   = ST_EMPTY;
            end else begin
              ram_rd_en   = 1'b1;
              ram_rd_addr = top_addr;
              ptr_nxt     = top_addr - AW'(1);
              cnt_nxt     = fill_r;
            end
          end
          default: begin
            ov_nxt    = 1'b1;
            olast_nxt = 1'b1;
          end
        endcase
      end
      S_RD_RSP: begin
        ov_nxt    = 1'b1;
        olast_nxt = 1'b1;
        if (cmd_r == CMD_DUP) begin
          ram_wr_en   = 1'b1;
          ram_wr_addr = AW'(fill_r);
          ram_wr_data = ram_rd_data;
          fill_nxt    = fill_r + FW'(1);
        end else begin
          oval_nxt = ram_rd_data;
          ovv_nxt  = 1'b1;
          if (cmd_r == CMD_POP) begin
            fill_nxt = fill_r - FW'(1);
          end
        end
      end
      S_ROT_SAVE: begin
        // Hold the wrapping entry, fetch the first one to move
        hold_nxt    = ram_rd_data;
        ram_rd_en   = 1'b1;
        ram_rd_addr = ptr_r;
        ptr_nxt     = dir_up_r ? ptr_r - AW'(1) : ptr_r + AW'(1);
      end
      S_ROT_MOVE: begin
        // Shift one entry while fetching the next
        ram_wr_en   = 1'b1;
        ram_wr_addr = wptr_r;
        ram_wr_data = ram_rd_data;
        wptr_nxt    = dir_up_r ? wptr_r - AW'(1) : wptr_r + AW'(1);
        cnt_nxt     = cnt_r - FW'(1);
        if (cnt_r > FW'(1)) begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = ptr_r;
          ptr_nxt     = dir_up_r ? ptr_r - AW'(1) : ptr_r + AW'(1);
        end
      end
      S_ROT_TAIL: begin
        // Drop the held entry into the vacated slot
        ram_wr_en   = 1'b1;
        ram_wr_addr = wptr_r;
        ram_wr_data = hold_r;
        ov_nxt      = 1'b1;
        olast_nxt   = 1'b1;
      end
      S_PRINT: begin
        // Emit one entry, fetch the next one down
        ov_nxt    = 1'b1;
        oval_nxt  = ram_rd_data;
        ovv_nxt   = 1'b1;
        olast_nxt = (cnt_r == FW'(1));
        cnt_nxt   = cnt_r - FW'(1);
        if (cnt_r > FW'(1)) begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = ptr_r;
          ptr_nxt     = ptr_r - AW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r  <= '0;
      cap_r   <= CAP_RESET;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      cap_r   <= cap_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    pv_r     <= pv_nxt;
    rc_r     <= rc_nxt;
    cnt_r    <= cnt_nxt;
    ptr_r    <= ptr_nxt;
    wptr_r   <= wptr_nxt;
    hold_r   <= hold_nxt;
    dir_up_r <= dir_up_nxt;
    ost_r    <= ost_nxt;
    oval_r   <= oval_nxt;
    ovv_r    <= ovv_nxt;
    olast_r  <= olast_nxt;
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = ov_r;
  assign out_status      = ost_r;
  assign out_value       = oval_r;
  assign out_value_valid = ovv_r;
  assign out_last        = olast_r;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CW'(fill_r) <= CW'(DEPTH))
    else $error("fill level beyond stack depth");

  a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("item taken but block not busy");

  a_print_stream: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |=> out_valid)
    else $error("print stream broke before last item");

  a_value_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_value_valid |-> (out_valid && out_status == ST_OK))
    else $error("value carried without ok result");

  a_no_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (!busy && !$past(busy)) |-> !out_valid)
    else $error("result without a pending item");
`endif

endmodule

[bench/rotating_stack_engine_tb.sv]
`timescale 1ns / 100ps

module rotating_stack_engine_tb;
  import rse_pkg::*;

  localparam int STACK_DEPTH = 16;
  localparam int STALL_LIMIT = 2000;
  localparam int ITEMS_PER_CHUNK = 67;
  // Code 7 has no name in the package; the block must treat it as a no-op
  localparam logic [CMD_W-1:0] CMD_UNKNOWN = 3'd7;

  // Track stack contents and hold the results each accepted item must produce
  class stack_tracker;
    typedef struct {
      logic [1:0]        status;
      logic [BYTE_W-1:0] value;
      logic              value_valid;
      logic              last;
    } result_t;

    logic [BYTE_W-1:0]  entries [STACK_DEPTH];
    int unsigned        fill;
    logic [COUNT_W-1:0] capacity;
    result_t            pending[$];
    int                 errors;

    function new();
      fill = 0;
      capacity = CAP_RESET;
      errors = 0;
    endfunction

    // Clamp the capacity register to the physical depth
    function int unsigned usable();
      return (capacity > STACK_DEPTH) ? STACK_DEPTH : capacity;
    endfunction

    function void set_capacity(logic [COUNT_W-1:0] v);
      capacity = v;
    endfunction

    function void queue_result(logic [1:0] st, logic [BYTE_W-1:0] val, logic vv, logic lst);
      result_t r;
      r.status = st;
      r.value = val;
      r.value_valid = vv;
      r.last = lst;
      pending.push_back(r);
    endfunction

    // Apply one accepted item to the stack and queue its results
    function void note_command(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] pv,
                               logic [COUNT_W-1:0] n);
      int unsigned lim;
      int unsigned base;
      logic [BYTE_W-1:0] held;
      lim = usable();
      case (cmd)
        CMD_PUSH: begin
          if (fill >= lim) begin
            queue_result(ST_FULL, '0, 1'b0, 1'b1);
          end else begin
            entries[fill] = pv;
            fill++;
            queue_result(ST_OK, '0, 1'b0, 1'b1);
          end
        end
        CMD_POP: begin
          if (fill == 0) begin
            queue_result(ST_EMPTY, '0, 1'b0, 1'b1);
          end else begin
            fill--;
            queue_result(ST_OK, entries[fill], 1'b1, 1'b1);
          end
        end
        CMD_PEEK: begin
          if (fill == 0) queue_result(ST_EMPTY, '0, 1'b0, 1'b1);
          else queue_result(ST_OK, entries[fill-1], 1'b1, 1'b1);
        end
        CMD_DUP: begin
          // empty wins over full
          if (fill == 0) begin
            queue_result(ST_EMPTY, '0, 1'b0, 1'b1);
          end else if (fill >= lim) begin
            queue_result(ST_FULL, '0, 1'b0, 1'b1);
          end else begin
            entries[fill] = entries[fill-1];
            fill++;
            queue_result(ST_OK, '0, 1'b0, 1'b1);
          end
        end
        CMD_ROT_UP, CMD_ROT_DN: begin
          if (n < 2 || n > fill) begin
            queue_result(ST_IGNORED, '0, 1'b0, 1'b1);
          end else begin
            base = fill - n;
            if (cmd == CMD_ROT_UP) begin
              // sink the top to the bottom of the window
              held = entries[fill-1];
              for (int i = fill - 1; i > base; i--) entries[i] = entries[i-1];
              entries[base] = held;
            end else begin
              // raise the bottom of the window to the top
              held = entries[base];
              for (int i = base; i + 1 < fill; i++) entries[i] = entries[i+1];
              entries[fill-1] = held;
            end
            queue_result(ST_OK, '0, 1'b0, 1'b1);
          end
        end
        CMD_PRINT: begin
          if (fill == 0) begin
            queue_result(ST_EMPTY, '0, 1'b0, 1'b1);
          end else begin
            for (int i = 0; i < fill; i++)
              queue_result(ST_OK, entries[fill-1-i], 1'b1, (i + 1 == fill));
          end
        end
        default: queue_result(ST_OK, '0, 1'b0, 1'b1);
      endcase
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    // Compare one result against the oldest expectation
    task check_result(logic [1:0] st, logic [BYTE_W-1:0] val, logic vv, logic lst);
      result_t want;
      if (pending.size() == 0) begin
        report($sformatf("result with nothing expected: status=%0d value=%02h", st, val));
        return;
      end
      want = pending.pop_front();
      if (st !== want.status)
        report($sformatf("status %0d, expected %0d", st, want.status));
      if (val !== want.value)
        report($sformatf("value %02h, expected %02h", val, want.value));
      if (vv !== want.value_valid)
        report($sformatf("value_valid %b, expected %b", vv, want.value_valid));
      if (lst !== want.last)
        report($sformatf("last %b, expected %b", lst, want.last));
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [CMD_W-1:0]   in_cmd = '0;
  logic [BYTE_W-1:0]  in_push_value = '0;
  logic [COUNT_W-1:0] in_rotate_count = '0;
  logic               cfg_we = 1'b0;
  logic [COUNT_W-1:0] cfg_wdata = '0;
  logic               out_valid;
  logic [1:0]         out_status;
  logic [BYTE_W-1:0]  out_value;
  logic               out_value_valid;
  logic               out_last;

  stack_tracker sb = new();
  bit           growing = 1'b1;
  int           stall_cycles = 0;

  rotating_stack_engine #(.DEPTH(STACK_DEPTH)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_cmd          (in_cmd),
    .in_push_value   (in_push_value),
    .in_rotate_count (in_rotate_count),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_value       (out_value),
    .out_value_valid (out_value_valid),
    .out_last        (out_last)
  );

  always #6 clk = ~clk;

  // Check every result strobe
  always @(posedge clk) begin
    if (rst_n && out_valid)
      sb.check_result(out_status, out_value, out_value_valid, out_last);
  end

  // Stop a hung run: count cycles with no item taken and no result
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Present one item and hold it until the block takes it
  task automatic send_cmd(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] pv,
                          logic [COUNT_W-1:0] n);
    start <= 1'b1;
    in_cmd <= cmd;
    in_push_value <= pv;
    in_rotate_count <= n;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_command(cmd, pv, n);
  endtask

  task automatic idle_gap(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Hold off until every expected result is in and the block is idle
  task automatic wait_drained();
    start <= 1'b0;
    while (sb.pending.size() != 0 || busy !== 1'b0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(logic [COUNT_W-1:0] v);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_capacity(v);
  endtask

  // Pick a command biased to sweep the stack between empty and full
  task automatic send_random();
    int unsigned roll;
    int unsigned lim;
    logic [CMD_W-1:0] cmd;
    logic [COUNT_W-1:0] n;
    lim = sb.usable();
    if (sb.fill == 0) growing = 1'b1;
    else if (sb.fill >= lim && $urandom_range(0, 3) == 0) growing = 1'b0;
    else if ($urandom_range(0, 49) == 0) growing = !growing;
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      // noise: any code, any count
      cmd = CMD_W'($urandom_range(0, 7));
      n = COUNT_W'($urandom_range(0, 31));
    end else begin
      roll = $urandom_range(0, 99);
      if (growing) begin
        if (roll < 40) cmd = CMD_PUSH;
        else if (roll < 50) cmd = CMD_POP;
        else if (roll < 58) cmd = CMD_PEEK;
        else if (roll < 68) cmd = CMD_DUP;
        else if (roll < 80) cmd = CMD_ROT_UP;
        else if (roll < 92) cmd = CMD_ROT_DN;
        else cmd = CMD_PRINT;
      end else begin
        if (roll < 10) cmd = CMD_PUSH;
        else if (roll < 45) cmd = CMD_POP;
        else if (roll < 53) cmd = CMD_PEEK;
        else if (roll < 60) cmd = CMD_DUP;
        else if (roll < 75) cmd = CMD_ROT_UP;
        else if (roll < 90) cmd = CMD_ROT_DN;
        else cmd = CMD_PRINT;
      end
      if (sb.fill >= 2 && $urandom_range(0, 5) != 0)
        n = COUNT_W'($urandom_range(2, sb.fill));
      else
        n = COUNT_W'($urandom_range(0, 31));
    end
    send_cmd(cmd, BYTE_W'($urandom_range(0, 255)), n);
  endtask

  initial begin
    logic [COUNT_W-1:0] caps [6];
    int idle_pct;

    // Reset
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Empty-stack cases and the unknown code
    send_cmd(CMD_POP, 8'h00, 5'd0);
    send_cmd(CMD_PEEK, 8'h00, 5'd0);
    send_cmd(CMD_DUP, 8'h00, 5'd0);
    send_cmd(CMD_PRINT, 8'h00, 5'd0);
    send_cmd(CMD_ROT_UP, 8'h00, 5'd2);
    send_cmd(CMD_UNKNOWN, 8'h5A, 5'd31);

    // Value extremes, dup, rotates in and out of range
    send_cmd(CMD_PUSH, 8'h00, 5'd0);
    send_cmd(CMD_PUSH, 8'hFF, 5'd0);
    send_cmd(CMD_PUSH, 8'hA5, 5'd0);
    send_cmd(CMD_PEEK, 8'h00, 5'd0);
    send_cmd(CMD_DUP, 8'h00, 5'd0);
    send_cmd(CMD_ROT_UP, 8'h00, 5'd3);
    send_cmd(CMD_ROT_DN, 8'h00, 5'd4);
    send_cmd(CMD_ROT_UP, 8'h00, 5'd1);
    send_cmd(CMD_ROT_DN, 8'h00, 5'd0);
    send_cmd(CMD_ROT_DN, 8'h00, 5'd5);
    send_cmd(CMD_ROT_UP, 8'h00, 5'd31);
    send_cmd(CMD_PRINT, 8'h00, 5'd0);
    send_cmd(CMD_POP, 8'h00, 5'd0);

    // Capacity below the fill level, then zero
    write_capacity(5'd2);
    send_cmd(CMD_PUSH, 8'h3C, 5'd0);
    send_cmd(CMD_DUP, 8'h00, 5'd0);
    write_capacity(5'd0);
    send_cmd(CMD_POP, 8'h00, 5'd0);
    send_cmd(CMD_PUSH, 8'hC3, 5'd0);
    send_cmd(CMD_DUP, 8'h00, 5'd0);
    send_cmd(CMD_PRINT, 8'h00, 5'd0);

    // Random traffic: light sender gaps, heavy gaps, then back to back
    caps[0] = 5'd16;
    caps[1] = 5'd5;
    caps[2] = 5'd1;
    caps[3] = 5'd31;
    caps[4] = COUNT_W'($urandom_range(2, 15));
    caps[5] = 5'd16;
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 10 : (phase == 1) ? 59 : 0;
      for (int chunk = 0; chunk < 2; chunk++) begin
        write_capacity(caps[phase*2 + chunk]);
        for (int k = 0; k < ITEMS_PER_CHUNK; k++) begin
          send_random();
          if ($urandom_range(0, 99) < idle_pct) idle_gap($urandom_range(1, 12));
        end
      end
    end

    // Drain and settle
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    while (sb.pending.size() != 0) begin
      void'(sb.pending.pop_front());
      sb.report("expected result never arrived");
    end

    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[rotating_stack_engine.f]
sv/rse_pkg.sv
sv/rse_ram.sv
sv/rotating_stack_engine.sv
bench/rotating_stack_engine_tb.sv
